// ----- hw/rtl/stplq_pkg.sv -----
package stplq_pkg;

   // Default sizing
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_WIDTH_DEF   = 32;

   // Request action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Priority levels; zero marks an empty slot
   localparam logic [1:0] PRIO_NONE = 2'd0;
   localparam logic [1:0] PRIO_LOW  = 2'd1;

   typedef struct packed {
      logic        action;
      logic [1:0]  priority_req;
      logic [31:0] entry_tag;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  out_priority;
      logic [31:0] out_tag;
      logic [4:0]  occupancy;
   } rsp_payload_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic       insert;
      logic       remove;
      logic [1:0] prio;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/stplq_cell.sv -----
module stplq_cell #(
   parameter int TAG_WIDTH = stplq_pkg::TAG_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stplq_pkg::cell_ctrl_type ctrl,
   input  logic [TAG_WIDTH-1:0]    new_tag,
   input  logic [1:0]              prev_prio,
   input  logic [TAG_WIDTH-1:0]    prev_tag,
   input  logic                    prev_lower,
   input  logic [1:0]              next_prio,
   input  logic [TAG_WIDTH-1:0]    next_tag,
   output logic [1:0]              prio,
   output logic [TAG_WIDTH-1:0]    tag,
   output logic                    lower
);
   import stplq_pkg::*;

   logic [1:0]           prio_ff, prio_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;

   // This slot holds something the new entry must pass
   assign lower = (prio_ff < ctrl.prio);

   // Insert: every entry from the insertion point on shifts down one slot, the
   // insertion point takes the new entry. Remove: everything moves up one slot.
   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (ctrl.insert) begin
         if (prev_lower) begin
            prio_in = prev_prio;
            tag_in  = prev_tag;
         end else if (lower) begin
            prio_in = ctrl.prio;
            tag_in  = new_tag;
         end
      end else if (ctrl.remove) begin
         prio_in = next_prio;
         tag_in  = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff <= PRIO_NONE;
      end else begin
         prio_ff <= prio_in;
      end
   end

   // Tags of empty slots are never read
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign prio = prio_ff;
   assign tag  = tag_ff;

endmodule

// ----- hw/rtl/stable_three_level_priority_queue.sv -----
// Channel   Direction  Ports                              Transfer when
// req       in         req_valid, req_stall, req_payload  req_valid && !req_stall
// rsp       out        rsp_valid, rsp_stall, rsp_payload  rsp_valid && !rsp_stall
//
// One operation per cycle while req_stall is low: each cell updates from its
// neighbors in the same cycle, and the result appears in the output register on the next cycle.
// Reset clears all slot priorities and the count; tags are left as they are.
// req_stall is high only while a result sits in the output register and
// rsp_stall holds it there.
module stable_three_level_priority_queue #(
   parameter int QUEUE_DEPTH = stplq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_WIDTH   = stplq_pkg::TAG_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  stplq_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output stplq_pkg::rsp_payload_type rsp_payload
);
   import stplq_pkg::*;

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 do_insert;
   logic                 do_remove;
   cell_ctrl_type        ctrl;
   logic [TAG_WIDTH-1:0] new_tag;

   logic [1:0]           cell_prio  [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0] cell_tag   [QUEUE_DEPTH];
   logic                 cell_lower [QUEUE_DEPTH];

   logic [CntW-1:0]      count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   // Handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = accept && (req_payload.action == ACT_INSERT) && !full;
   assign do_remove = accept && (req_payload.action == ACT_REMOVE) && !empty;

   // Priority zero is taken as the lowest level
   always_comb begin
      ctrl.insert = do_insert;
      ctrl.remove = do_remove;
      ctrl.prio   = (req_payload.priority_req == PRIO_NONE) ? PRIO_LOW
                                                            : req_payload.priority_req;
   end
   assign new_tag = TAG_WIDTH'(req_payload.entry_tag);

   // Row of slots, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [1:0]           p_prio;
      logic [TAG_WIDTH-1:0] p_tag;
      logic                 p_lower;
      logic [1:0]           n_prio;
      logic [TAG_WIDTH-1:0] n_tag;

      if (i == 0) begin : g_head
         assign p_prio  = PRIO_NONE;
         assign p_tag   = '0;
         assign p_lower = 1'b0;
      end else begin : g_body
         assign p_prio  = cell_prio[i-1];
         assign p_tag   = cell_tag[i-1];
         assign p_lower = cell_lower[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign n_prio = PRIO_NONE;
         assign n_tag  = '0;
      end else begin : g_mid
         assign n_prio = cell_prio[i+1];
         assign n_tag  = cell_tag[i+1];
      end

      stplq_cell #(
         .TAG_WIDTH (TAG_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_tag    (new_tag),
         .prev_prio  (p_prio),
         .prev_tag   (p_tag),
         .prev_lower (p_lower),
         .next_prio  (n_prio),
         .next_tag   (n_tag),
         .prio       (cell_prio[i]),
         .tag        (cell_tag[i]),
         .lower      (cell_lower[i])
      );
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CntW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // Result for the accepted operation
   always_comb begin
      rsp_payload_in.status       = STATUS_DONE;
      rsp_payload_in.out_priority = PRIO_NONE;
      rsp_payload_in.out_tag      = '0;
      rsp_payload_in.occupancy    = 5'(count_in);
      if (req_payload.action == ACT_INSERT) begin
         if (full) begin
            rsp_payload_in.status = STATUS_FULL;
         end
      end else begin
         if (empty) begin
            rsp_payload_in.status = STATUS_EMPTY;
         end else begin
            rsp_payload_in.out_priority = cell_prio[0];
            rsp_payload_in.out_tag      = 32'(cell_tag[0]);
         end
      end
   end

   // Output register: loads on every transfer in, drops when taken
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (cell_prio[0] == PRIO_NONE))
      else $error("head slot occupancy disagrees with entry count");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      cell_prio[0] >= cell_prio[1])
      else $error("first two slots out of priority order");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      do_remove |=> (count_ff == $past(count_ff) - CntW'(1)))
      else $error("remove did not decrement the entry count");

endmodule
